@@ hdl/ppmfd_pkg.sv @@
// ppmfd_pkg: shared widths, register codes, reset values and axis scaling constants
// for the pulse-position frame decoder; no dependencies
`default_nettype none

package ppmfd_pkg;

  localparam int TIMER_PERIOD_DEF = 60000;

  localparam int TS_W      = 16;
  localparam int CH_W      = 15;
  localparam int AXIS_W    = 14;
  localparam int CNT_W     = 16;
  localparam int NUM_AXES  = 4;
  localparam int NUM_CH    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_GAP_MIN = 3'd0,
    REG_PULSE_LOW    = 3'd1,
    REG_PULSE_HIGH   = 3'd2,
    REG_CHECK_LOW    = 3'd3,
    REG_CHECK_HIGH   = 3'd4
  } cfg_idx_t;

  localparam logic [TS_W-1:0] SYNC_GAP_MIN_RST = 16'd15000;
  localparam logic [CH_W-1:0] PULSE_LOW_RST    = 15'd1700;
  localparam logic [CH_W-1:0] PULSE_HIGH_RST   = 15'd4300;
  localparam logic [CH_W-1:0] CHECK_LOW_RST    = 15'd2700;
  localparam logic [CH_W-1:0] CHECK_HIGH_RST   = 15'd2799;

  typedef struct packed {
    logic [TS_W-1:0] sync_gap_min;
    logic [CH_W-1:0] pulse_low;
    logic [CH_W-1:0] pulse_high;
    logic [CH_W-1:0] check_low;
    logic [CH_W-1:0] check_high;
  } cfg_t;

  // per-request status carried down the pipeline
  typedef struct packed {
    logic             accepted;
    logic             in_frame;
    logic [CNT_W-1:0] edge_count;
  } frame_t;

  typedef logic [CH_W-1:0] ch_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  // axis scaling: axis = gain * (raw - center) / span, truncated toward zero
  localparam int ROLL_SPAN  = 3458 - 1907;
  localparam int PITCH_SPAN = 3465 - 1993;
  localparam int THR_SPAN   = 4090 - 2118;
  localparam int YAW_SPAN   = 4099 - 2639;

  localparam int AXIS_CENTER [NUM_AXES] = '{2707, 2750, 2118, 3407};
  localparam int AXIS_GAIN   [NUM_AXES] = '{200, 200, 100, 200};
  localparam int AXIS_SPAN   [NUM_AXES] = '{ROLL_SPAN, PITCH_SPAN, THR_SPAN, YAW_SPAN};

  // reciprocal estimate: q_est = (mag * recip) >> RECIP_SHIFT is q or q - 1
  // as long as mag < 2**RECIP_SHIFT
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 14;
  localparam int AXIS_RECIP  [NUM_AXES] = '{
    (1 << RECIP_SHIFT) / ROLL_SPAN,
    (1 << RECIP_SHIFT) / PITCH_SPAN,
    (1 << RECIP_SHIFT) / THR_SPAN,
    (1 << RECIP_SHIFT) / YAW_SPAN
  };

  localparam int SPAN_W = 11;
  localparam int DIFF_W = CH_W + 2;      // signed raw - center
  localparam int GAIN_W = 9;             // signed gain
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int MAG_W  = 23;            // |gain * (raw - center)| < 2**23
  localparam int QUO_W  = AXIS_W - 1;    // magnitude of the quotient
  localparam int REM_W  = QUO_W + SPAN_W;

endpackage

`default_nettype wire

@@ hdl/ppm_frame_decoder_top.sv @@
// ppm_frame_decoder_top: pulse-position frame decoder, top level
// depends on ppmfd_pkg, ppmfd_cfg_regs, ppmfd_capture, ppmfd_scale
`default_nettype none

// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_ready    | timestamp
// output   | out_valid / out_ready  | frame_accepted, in_frame, axis_*, edge_count
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one request per cycle sustained while out_ready holds; a request taken into the input register
// then passes through the capture stage, two scaling stages and the output register
// the capture stage updates frame state as each request leaves the input register, so edges may arrive back to back
// each stage loads when empty or when the stage after it moves, so bubbles collapse
// and the input keeps flowing into empty stages while a finished result waits in the output register
// synchronous reset clears frame state, axes and edge count and loads the config registers with their reset values

module ppm_frame_decoder_top #(
  parameter int TIMER_PERIOD = ppmfd_pkg::TIMER_PERIOD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ppmfd_pkg::TS_W-1:0]          timestamp,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                frame_accepted,
  output logic                                in_frame,
  output logic signed [ppmfd_pkg::AXIS_W-1:0] axis_roll,
  output logic signed [ppmfd_pkg::AXIS_W-1:0] axis_pitch,
  output logic signed [ppmfd_pkg::AXIS_W-1:0] axis_throttle,
  output logic signed [ppmfd_pkg::AXIS_W-1:0] axis_yaw,
  output logic [ppmfd_pkg::CNT_W-1:0]         edge_count,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppmfd_pkg::CFG_DAT_W-1:0]     cfg_data
);

  ppmfd_pkg::cfg_t                                   cfg;
  ppmfd_pkg::frame_t                                 frame1, frame2, frame3;
  ppmfd_pkg::ch_t   [ppmfd_pkg::NUM_AXES-1:0]        raw1;
  ppmfd_pkg::axis_t [ppmfd_pkg::NUM_AXES-1:0]        axis3;

  // stage valids: v0 input register, v1 capture, v2/v3 scaling
  logic                                v0, v1, v2, v3;
  logic                                en1, en2, en3, en4;
  logic [ppmfd_pkg::TS_W-1:0]          ts0;

  // per-stage load enables, back to front
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = !v0 || en1;

  ppmfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) ts0 <= timestamp;
  end

  // frame state advances exactly once per request, as it leaves the input register
  ppmfd_capture #(
    .TIMER_PERIOD (TIMER_PERIOD)
  ) u_capture (
    .clk   (clk),
    .rst   (rst),
    .step  (en1 && v0),
    .ts    (ts0),
    .cfg   (cfg),
    .frame (frame1),
    .raw   (raw1)
  );

  ppmfd_scale u_scale (
    .clk  (clk),
    .en_a (en2),
    .en_b (en3),
    .raw  (raw1),
    .axis (axis3)
  );

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // status travels alongside the scaling stages
  always_ff @(posedge clk) begin
    if (en2) frame2 <= frame1;
    if (en3) frame3 <= frame2;
  end

  // output register; the axis fields double as the held axis values
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_roll     <= '0;
      axis_pitch    <= '0;
      axis_throttle <= '0;
      axis_yaw      <= '0;
    end else if (en4 && v3 && frame3.accepted) begin
      axis_roll     <= axis3[0];
      axis_pitch    <= axis3[1];
      axis_throttle <= axis3[2];
      axis_yaw      <= axis3[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      frame_accepted <= frame3.accepted;
      in_frame       <= frame3.in_frame;
      edge_count     <= frame3.edge_count;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ppmfd_cfg_regs.sv @@
// ppmfd_cfg_regs: configuration register file written over the cfg channel
// depends on ppmfd_pkg
`default_nettype none

module ppmfd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppmfd_pkg::CFG_DAT_W-1:0]     cfg_data,
  output ppmfd_pkg::cfg_t                     cfg
);

  ppmfd_pkg::cfg_idx_t idx;

  assign cfg_ready = 1'b1;
  assign idx       = ppmfd_pkg::cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_gap_min <= ppmfd_pkg::SYNC_GAP_MIN_RST;
      cfg.pulse_low    <= ppmfd_pkg::PULSE_LOW_RST;
      cfg.pulse_high   <= ppmfd_pkg::PULSE_HIGH_RST;
      cfg.check_low    <= ppmfd_pkg::CHECK_LOW_RST;
      cfg.check_high   <= ppmfd_pkg::CHECK_HIGH_RST;
    end else if (cfg_valid) begin
      unique case (idx)
        ppmfd_pkg::REG_SYNC_GAP_MIN: cfg.sync_gap_min <= cfg_data;
        ppmfd_pkg::REG_PULSE_LOW:    cfg.pulse_low    <= cfg_data[ppmfd_pkg::CH_W-1:0];
        ppmfd_pkg::REG_PULSE_HIGH:   cfg.pulse_high   <= cfg_data[ppmfd_pkg::CH_W-1:0];
        ppmfd_pkg::REG_CHECK_LOW:    cfg.check_low    <= cfg_data[ppmfd_pkg::CH_W-1:0];
        ppmfd_pkg::REG_CHECK_HIGH:   cfg.check_high   <= cfg_data[ppmfd_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/ppmfd_capture.sv @@
// ppmfd_capture: edge interval, sync detect, channel store and frame check
// depends on ppmfd_pkg
`default_nettype none

module ppmfd_capture #(
  parameter int TIMER_PERIOD = ppmfd_pkg::TIMER_PERIOD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [ppmfd_pkg::TS_W-1:0]        ts,
  input  ppmfd_pkg::cfg_t                   cfg,
  output ppmfd_pkg::frame_t                 frame,
  output ppmfd_pkg::ch_t [ppmfd_pkg::NUM_AXES-1:0] raw
);

  localparam logic [2:0] PHASE_IDLE = 3'd0;
  localparam logic [2:0] PHASE_LAST = 3'd6;
  localparam logic [ppmfd_pkg::TS_W-1:0] PERIOD = ppmfd_pkg::TS_W'(TIMER_PERIOD);

  logic [2:0]                       phase, phase_next;
  logic [ppmfd_pkg::TS_W-1:0]       last_ts;
  logic [ppmfd_pkg::CNT_W-1:0]      edge_counter, edge_counter_next;
  ppmfd_pkg::ch_t                   store [ppmfd_pkg::NUM_CH];

  logic [ppmfd_pkg::TS_W-1:0]       delta;
  logic                             in_range;
  logic                             store_we;
  logic [2:0]                       store_idx;
  logic                             check_ok;
  logic                             accepted;

  always_comb begin
    if (last_ts < ts) delta = ts - last_ts;
    else              delta = PERIOD - (last_ts - ts);
  end

  assign in_range = (delta > {1'b0, cfg.pulse_low}) && (delta < {1'b0, cfg.pulse_high});
  assign store_idx = phase - 3'd1;

  // channel six is the interval being stored right now
  assign check_ok = (store[4] > cfg.check_low) && (store[4] < cfg.check_high) &&
                    (delta > {1'b0, cfg.check_low}) && (delta < {1'b0, cfg.check_high});

  assign edge_counter_next = edge_counter + 1'b1;

  always_comb begin
    phase_next = phase;
    store_we   = 1'b0;
    accepted   = 1'b0;
    if (phase == PHASE_IDLE) begin
      if (delta > cfg.sync_gap_min) phase_next = 3'd1;
    end else if (in_range) begin
      store_we = 1'b1;
      if (phase == PHASE_LAST) begin
        accepted   = check_ok;
        phase_next = PHASE_IDLE;
      end else begin
        phase_next = phase + 3'd1;
      end
    end else begin
      // bad interval: restart at channel one without a new sync
      phase_next = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_IDLE;
      last_ts      <= '0;
      edge_counter <= '0;
    end else if (step) begin
      phase        <= phase_next;
      last_ts      <= ts;
      edge_counter <= edge_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_we) store[store_idx] <= delta[ppmfd_pkg::CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame.accepted   <= accepted;
      frame.in_frame   <= (phase_next != PHASE_IDLE);
      frame.edge_count <= edge_counter_next;
      for (int i = 0; i < ppmfd_pkg::NUM_AXES; i++) raw[i] <= store[i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ppmfd_scale.sv @@
// ppmfd_scale: two-stage offset, gain and reciprocal divide for the four axes
// depends on ppmfd_pkg
`default_nettype none

module ppmfd_scale (
  input  logic                                      clk,
  input  logic                                      en_a,
  input  logic                                      en_b,
  input  ppmfd_pkg::ch_t [ppmfd_pkg::NUM_AXES-1:0]  raw,
  output ppmfd_pkg::axis_t [ppmfd_pkg::NUM_AXES-1:0] axis
);

  localparam int N = ppmfd_pkg::NUM_AXES;

  logic [ppmfd_pkg::MAG_W-1:0] mag_a [N];
  logic                        neg_a [N];
  logic [ppmfd_pkg::MAG_W-1:0] mag_b [N];
  logic                        neg_b [N];
  logic [ppmfd_pkg::QUO_W-1:0] est_b [N];

  // stage a: signed offset times gain, split into sign and magnitude
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < N; i++) begin
        logic signed [ppmfd_pkg::DIFF_W-1:0] diff;
        logic signed [ppmfd_pkg::PROD_W-1:0] prod;
        logic signed [ppmfd_pkg::PROD_W-1:0] pmag;
        diff = $signed({2'b00, raw[i]}) -
               $signed(ppmfd_pkg::DIFF_W'(ppmfd_pkg::AXIS_CENTER[i]));
        prod = diff * $signed(ppmfd_pkg::GAIN_W'(ppmfd_pkg::AXIS_GAIN[i]));
        pmag = (prod < 0) ? -prod : prod;
        neg_a[i] <= (prod < 0);
        mag_a[i] <= pmag[ppmfd_pkg::MAG_W-1:0];
      end
    end
  end

  // stage b: quotient estimate by reciprocal, low by at most one
  always_ff @(posedge clk) begin
    if (en_b) begin
      for (int i = 0; i < N; i++) begin
        logic [ppmfd_pkg::MAG_W+ppmfd_pkg::RECIP_W-1:0] p;
        p = mag_a[i] * ppmfd_pkg::RECIP_W'(ppmfd_pkg::AXIS_RECIP[i]);
        est_b[i] <= p[ppmfd_pkg::RECIP_SHIFT +: ppmfd_pkg::QUO_W];
        mag_b[i] <= mag_a[i];
        neg_b[i] <= neg_a[i];
      end
    end
  end

  // correction and sign
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [ppmfd_pkg::REM_W-1:0]   qs;
      logic [ppmfd_pkg::REM_W-1:0]   rem;
      logic [ppmfd_pkg::AXIS_W-1:0]  q;
      qs  = ppmfd_pkg::REM_W'(est_b[i]) * ppmfd_pkg::SPAN_W'(ppmfd_pkg::AXIS_SPAN[i]);
      rem = ppmfd_pkg::REM_W'(mag_b[i]) - qs;
      q   = {1'b0, est_b[i]} +
            ppmfd_pkg::AXIS_W'(rem >= ppmfd_pkg::REM_W'(ppmfd_pkg::AXIS_SPAN[i]));
      axis[i] = neg_b[i] ? -$signed(q) : $signed(q);
    end
  end

endmodule

`default_nettype wire
